FILE: rtl/kcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kcl_pkg;

   localparam int CODE_DIGITS = 4;
   localparam int BUF_LEN     = CODE_DIGITS + 2;
   localparam int FILL_W      = $clog2(BUF_LEN + 1);

   localparam logic [7:0] KEY_CLOSE   = 8'h0C;
   localparam logic [7:0] KEY_SETCODE = 8'h0B;
   localparam logic [7:0] KEY_OPEN    = 8'h0A;
   localparam logic [7:0] EMPTY_MARK  = 8'hFF;

   typedef enum logic {
      CMD_KEY    = 1'b0,
      CMD_DECODE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      OP_UNCHANGED    = 3'd0,
      OP_CLOSING      = 3'd1,
      OP_CODE_CHANGED = 3'd2,
      OP_OPENING      = 3'd3,
      OP_WRONG        = 3'd4
   } op_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] key_value;
   } req_type;

   typedef struct packed {
      logic   key_refused;
      op_type operation;
      logic   is_closed;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/keypad_code_lock_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// The result of an accepted beat is registered in out_ff, or in skid_ff while out_ff is held, before it shows on rsp_.
// Throughput: one beat per cycle while req_stall is low; the lock state update is a single pass of compares.
// A two-entry output buffer keeps req_ taking beats while a result waits; req_stall
// rises only when both entries are full.
// Reset (synchronous, active high): buffer refilled with 0xFF, fill count zero,
// lock open, stored code all zero, output buffer empty.

module keypad_code_lock_unit (
   input  wire             clock,
   input  wire             reset,
   input  wire             req_valid,
   output logic            req_stall,
   input  wire kcl_pkg::req_type req_data,
   output logic            rsp_valid,
   input  wire             rsp_stall,
   output kcl_pkg::rsp_type rsp_data
);

   logic [7:0] buf_ff  [kcl_pkg::BUF_LEN];
   logic [7:0] buf_in  [kcl_pkg::BUF_LEN];
   logic [7:0] code_ff [kcl_pkg::CODE_DIGITS];
   logic [7:0] code_in [kcl_pkg::CODE_DIGITS];
   logic [kcl_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic closed_ff, closed_in;

   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   kcl_pkg::rsp_type out_ff, out_in;
   kcl_pkg::rsp_type skid_ff, skid_in;
   kcl_pkg::rsp_type result;

   logic accept, take, match;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      buf_in    = buf_ff;
      code_in   = code_ff;
      fill_in   = fill_ff;
      closed_in = closed_ff;
      result.key_refused = 1'b0;
      result.operation   = kcl_pkg::OP_UNCHANGED;
      match = (fill_ff == kcl_pkg::FILL_W'(kcl_pkg::CODE_DIGITS + 1));
      for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++) begin
         if (buf_ff[i+1] != code_ff[i]) match = 1'b0;
      end
      unique case (req_data.cmd)
         kcl_pkg::CMD_KEY: begin
            if (fill_ff < kcl_pkg::FILL_W'(kcl_pkg::BUF_LEN)) begin
               for (int i = 0; i < kcl_pkg::BUF_LEN; i++) begin
                  if (fill_ff == kcl_pkg::FILL_W'(i)) buf_in[i] = req_data.key_value;
               end
               fill_in = fill_ff + kcl_pkg::FILL_W'(1);
            end else begin
               result.key_refused = 1'b1;
            end
         end
         kcl_pkg::CMD_DECODE: begin
            if (fill_ff != '0) begin
               if (!closed_ff) begin
                  if (buf_ff[0] == kcl_pkg::KEY_CLOSE && fill_ff == kcl_pkg::FILL_W'(1)) begin
                     closed_in = 1'b1;
                     result.operation = kcl_pkg::OP_CLOSING;
                  end else if (buf_ff[0] == kcl_pkg::KEY_SETCODE &&
                               fill_ff <= kcl_pkg::FILL_W'(kcl_pkg::CODE_DIGITS + 1)) begin
                     for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++) code_in[i] = buf_ff[i+1];
                     result.operation = kcl_pkg::OP_CODE_CHANGED;
                  end
               end else if (buf_ff[0] == kcl_pkg::KEY_OPEN) begin
                  if (match) begin
                     closed_in = 1'b0;
                     result.operation = kcl_pkg::OP_OPENING;
                  end else begin
                     result.operation = kcl_pkg::OP_WRONG;
                  end
               end
               for (int i = 0; i < kcl_pkg::BUF_LEN; i++) buf_in[i] = kcl_pkg::EMPTY_MARK;
               fill_in = '0;
            end
         end
         default: ;
      endcase
      result.is_closed = closed_in;
   end

   // two-entry output buffer; a new beat only lands in skid when out is held
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         fill_ff       <= '0;
         closed_ff     <= 1'b0;
         for (int i = 0; i < kcl_pkg::BUF_LEN; i++) buf_ff[i] <= kcl_pkg::EMPTY_MARK;
         for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++) code_ff[i] <= 8'h00;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (accept) begin
            fill_ff   <= fill_in;
            closed_ff <= closed_in;
            buf_ff    <= buf_in;
            code_ff   <= code_in;
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/kcl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module kcl_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_stall,
   input wire kcl_pkg::req_type req_data,
   input wire              rsp_valid,
   input wire              rsp_stall,
   input wire kcl_pkg::rsp_type rsp_data
);

   // nothing comes out of the output buffer in the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // input back-pressure only once a result is already waiting
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall high with output buffer empty");

   a_op_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.operation != kcl_pkg::OP_CLOSING || rsp_data.is_closed) &&
                     (rsp_data.operation != kcl_pkg::OP_OPENING || !rsp_data.is_closed) &&
                     (rsp_data.operation != kcl_pkg::OP_WRONG || rsp_data.is_closed)))
      else $error("operation disagrees with lock state");

   a_refused_no_op: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.key_refused |-> rsp_data.operation == kcl_pkg::OP_UNCHANGED)
      else $error("refused key beat carries an operation");

endmodule

bind keypad_code_lock_unit kcl_checker u_kcl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: tb/sv/keypad_code_lock_checker.sv
`timescale 1ns / 1ps

module keypad_code_lock_checker
   import kcl_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   input  wire     req_stall,
   input  req_type req_data,
   input  wire     rsp_valid,
   input  wire     rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending,
   output int      n_results,
   output int      n_refused,
   output int      n_closing,
   output int      n_code_changed,
   output int      n_opening,
   output int      n_wrong
);

   logic [7:0]  entry_keys [BUF_LEN];
   int unsigned entry_count;
   logic        shut_state;
   logic [7:0]  code_digits [CODE_DIGITS];
   rsp_type     expected_lock_q[$];

   function automatic void clear_entry();
      for (int i = 0; i < BUF_LEN; i++) begin
         entry_keys[i] = EMPTY_MARK;
      end
      entry_count = 0;
   endfunction

   task automatic predict_lock(input req_type beat, output rsp_type outcome);
      op_type op;
      logic   refused;
      logic   match;
      refused = 1'b0;
      op      = OP_UNCHANGED;
      if (beat.cmd == CMD_KEY) begin
         if (entry_count < BUF_LEN) begin
            entry_keys[entry_count] = beat.key_value;
            entry_count++;
         end else begin
            refused = 1'b1;
         end
      end else if (entry_count != 0) begin
         if (!shut_state) begin
            if (entry_keys[0] == KEY_CLOSE && entry_count == 1) begin
               shut_state = 1'b1;
               op         = OP_CLOSING;
            end else if (entry_keys[0] == KEY_SETCODE && entry_count <= CODE_DIGITS + 1) begin
               // digits not keyed in are taken as the empty mark
               for (int i = 0; i < CODE_DIGITS; i++) begin
                  code_digits[i] = entry_keys[i + 1];
               end
               op = OP_CODE_CHANGED;
            end
         end else if (entry_keys[0] == KEY_OPEN) begin
            // length comes from the count, so 0xFF keys are real keys
            match = (entry_count == CODE_DIGITS + 1);
            for (int i = 0; i < CODE_DIGITS; i++) begin
               if (entry_keys[i + 1] != code_digits[i]) match = 1'b0;
            end
            if (match) begin
               shut_state = 1'b0;
               op         = OP_OPENING;
            end else begin
               op = OP_WRONG;
            end
         end
         clear_entry();
      end
      outcome.key_refused = refused;
      outcome.operation   = op;
      outcome.is_closed   = shut_state;
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         clear_entry();
         shut_state = 1'b0;
         for (int i = 0; i < CODE_DIGITS; i++) begin
            code_digits[i] = 8'h00;
         end
         expected_lock_q.delete();
      end else begin
         // result first: a beat taken at this edge cannot already have its result out
         if (rsp_valid && !rsp_stall) begin
            if (expected_lock_q.size() == 0) begin
               $error("result beat with no result expected");
               fail_count++;
            end else begin
               want = expected_lock_q.pop_front();
               n_results++;
               if (rsp_data.key_refused !== want.key_refused) begin
                  $error("key_refused: expected %0b, actual %0b",
                         want.key_refused, rsp_data.key_refused);
                  fail_count++;
               end
               if (rsp_data.operation !== want.operation) begin
                  $error("operation: expected %0d, actual %0d",
                         want.operation, rsp_data.operation);
                  fail_count++;
               end
               if (rsp_data.is_closed !== want.is_closed) begin
                  $error("is_closed: expected %0b, actual %0b",
                         want.is_closed, rsp_data.is_closed);
                  fail_count++;
               end
               if (want.key_refused) n_refused++;
               case (want.operation)
                  OP_CLOSING:      n_closing++;
                  OP_CODE_CHANGED: n_code_changed++;
                  OP_OPENING:      n_opening++;
                  OP_WRONG:        n_wrong++;
                  default: ;
               endcase
            end
         end
         if (req_valid && !req_stall) begin
            predict_lock(req_data, want);
            expected_lock_q.push_back(want);
         end
      end
      pending = expected_lock_q.size();
   end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import kcl_pkg::*;

   localparam int RANDOM_ITEMS = 450;
   localparam int IDLE_LIMIT   = 1000;
   localparam int TAIL_CYCLES  = 5;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int n_results;
   int n_refused;
   int n_closing;
   int n_code_changed;
   int n_opening;
   int n_wrong;

   int         items_sent  = 0;
   int         idle_cycles = 0;
   int         stall_hold  = 0;
   logic       quiet       = 1'b0;
   logic [7:0] entry_q[$];
   logic [7:0] shadow_code [CODE_DIGITS];

   keypad_code_lock_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   keypad_code_lock_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .fail_count     (fail_count),
      .pending        (pending),
      .n_results      (n_results),
      .n_refused      (n_refused),
      .n_closing      (n_closing),
      .n_code_changed (n_code_changed),
      .n_opening      (n_opening),
      .n_wrong        (n_wrong)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // result side back-pressure: free runs, short stalls, the odd long one
   always @(posedge clock) begin
      if (quiet) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               rsp_stall  <= 1'b0;
               stall_hold <= $urandom_range(0, 8);
            end
            9: begin
               rsp_stall  <= 1'b1;
               stall_hold <= $urandom_range(5, 30);
            end
            default: begin
               rsp_stall  <= 1'b1;
               stall_hold <= $urandom_range(0, 2);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] pick_digit();
      if ($urandom_range(0, 4) != 0) return 8'($urandom_range(0, 9));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_beat(input cmd_type c, input logic [7:0] k);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data.cmd       <= c;
      req_data.key_value <= k;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // key in everything queued, then decode
   task automatic play_entry();
      foreach (entry_q[i]) send_beat(CMD_KEY, entry_q[i]);
      send_beat(CMD_DECODE, 8'($urandom_range(0, 255)));
      entry_q.delete();
   endtask

   task automatic queue_code_entry();
      entry_q.push_back(KEY_OPEN);
      for (int i = 0; i < CODE_DIGITS; i++) entry_q.push_back(shadow_code[i]);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // open with the code in force, set a fresh one, close, miss a few times, open
   task automatic run_lock_cycle();
      int n;
      int pick;
      logic [7:0] d;
      queue_code_entry();
      play_entry();
      n = $urandom_range(0, CODE_DIGITS);
      entry_q.push_back(KEY_SETCODE);
      for (int i = 0; i < CODE_DIGITS; i++) begin
         if (i < n) begin
            d = pick_digit();
            entry_q.push_back(d);
            shadow_code[i] = d;
         end else begin
            shadow_code[i] = EMPTY_MARK;
         end
      end
      play_entry();
      entry_q.push_back(KEY_CLOSE);
      play_entry();
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(0, 3))
            0: begin
               queue_code_entry();
               pick = $urandom_range(1, CODE_DIGITS);
               entry_q[pick] = entry_q[pick] ^ 8'($urandom_range(1, 255));
            end
            1: begin
               entry_q.push_back(KEY_OPEN);
               n = $urandom_range(0, CODE_DIGITS - 1);
               for (int i = 0; i < n; i++) entry_q.push_back(shadow_code[i]);
            end
            2: begin
               // too long; past six keys the extras are refused
               queue_code_entry();
               repeat ($urandom_range(1, 3)) entry_q.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
               repeat ($urandom_range(1, BUF_LEN + 1))
                  entry_q.push_back(8'($urandom_range(0, 255)));
            end
         endcase
         play_entry();
      end
      queue_code_entry();
      play_entry();
   endtask

   // noise while open; never a valid close or set-code, so the shadow code holds
   task automatic run_noise();
      logic [7:0] d;
      case ($urandom_range(0, 3))
         0: begin
            repeat ($urandom_range(0, BUF_LEN + 2)) begin
               d = 8'($urandom_range(0, 255));
               if (entry_q.size() == 0 && (d == KEY_SETCODE || d == KEY_CLOSE)) d = KEY_OPEN;
               entry_q.push_back(d);
            end
         end
         1: begin
            entry_q.push_back(KEY_SETCODE);
            repeat ($urandom_range(CODE_DIGITS + 1, BUF_LEN + 1))
               entry_q.push_back(pick_digit());
         end
         2: begin
            entry_q.push_back(KEY_CLOSE);
            repeat ($urandom_range(1, BUF_LEN)) entry_q.push_back(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
      play_entry();
   endtask

   initial begin : stimulus
      int directed_items;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // decode on an empty buffer
      play_entry();
      // short new code: the three missing digits become 0xFF
      entry_q = '{KEY_SETCODE, 8'h07};
      play_entry();
      entry_q = '{KEY_CLOSE};
      play_entry();
      // six keys fill the buffer, the seventh is refused; wrong length
      entry_q = '{KEY_OPEN, 8'h07, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80};
      play_entry();
      entry_q = '{KEY_OPEN, 8'h07, 8'hFF, 8'hFF, 8'hFF};
      play_entry();
      // unknown entry
      entry_q = '{8'h55};
      play_entry();
      shadow_code = '{8'h07, 8'hFF, 8'hFF, 8'hFF};
      directed_items = items_sent;
      wait_drained();

      while (items_sent < directed_items + RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 99) < 8) wait_drained();
         if ($urandom_range(0, 99) < 65) run_lock_cycle();
         else run_noise();
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d beats in, %0d results checked, %0d keys refused",
               items_sent, n_results, n_refused);
      $display("%0d closings, %0d code changes, %0d openings, %0d wrong codes",
               n_closing, n_code_changed, n_opening, n_wrong);
      if (fail_count == 0 && pending == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
